### rtl/utf8d_pkg.sv
// Shared types, constants and helper functions for the UTF-8 stream decoder.
// Used by utf8d_decode, utf8d_resq and utf8_stream_decoder; depends on nothing.
package utf8d_pkg;

    // Longest sequence the decoder accepts by default (legal range 4 to 6).
    localparam int MAX_SEQ_BYTES_DEF = 6;

    // Depth of the result queue; room for two results is needed per byte.
    localparam int RESQ_DEPTH = 4;

    localparam int CP_W    = 31;
    localparam int LEN_W   = 3;
    localparam int STAT_W  = 3;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_ILLEGAL  = 3'd2,
        ST_BADCONT  = 3'd3,
        ST_OVERLONG = 3'd4
    } t_status;

    // One result item.
    typedef struct packed {
        logic [CP_W-1:0]  codepoint;
        logic [LEN_W-1:0] seq_bytes;
        t_status          status;
        logic             final_result;
    } t_result;

    // Results produced by one accepted byte, handed to the result queue.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push;

    // Lead byte classification: length 0 means not a lead byte.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [6:0]       payload;
    } t_lead;

    // Classifies a byte as a lead byte and extracts its payload bits.
    function automatic t_lead lead_decode(input logic [7:0] b);
        t_lead l;
        l.len     = 3'd0;
        l.payload = 7'd0;
        priority if (b[7] == 1'b0) begin
            l.len     = 3'd1;
            l.payload = b[6:0];
        end else if ((b & 8'he0) == 8'hc0) begin
            l.len     = 3'd2;
            l.payload = {2'b00, b[4:0]};
        end else if ((b & 8'hf0) == 8'he0) begin
            l.len     = 3'd3;
            l.payload = {3'b000, b[3:0]};
        end else if ((b & 8'hf8) == 8'hf0) begin
            l.len     = 3'd4;
            l.payload = {4'b0000, b[2:0]};
        end else if ((b & 8'hfc) == 8'hf8) begin
            l.len     = 3'd5;
            l.payload = {5'b00000, b[1:0]};
        end else if ((b & 8'hfe) == 8'hfc) begin
            l.len     = 3'd6;
            l.payload = {6'b000000, b[0]};
        end else begin
            l.len     = 3'd0;
            l.payload = 7'd0;
        end
        return l;
    endfunction

    // Smallest legal value for a sequence of the given length.
    function automatic logic [CP_W-1:0] min_value(input logic [LEN_W-1:0] len);
        logic [CP_W-1:0] v;
        unique case (len)
            3'd2:    v = 31'h80;
            3'd3:    v = 31'h800;
            3'd4:    v = 31'h10000;
            3'd5:    v = 31'h200000;
            3'd6:    v = 31'h4000000;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/utf8d_decode.sv
// Sequence state registers and the single-pass byte decode logic.
// Depends on utf8d_pkg for the result types, lead decoding and minimum values.
module utf8d_decode #(
    parameter int MAX_SEQ_BYTES = utf8d_pkg::MAX_SEQ_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic                i_end_of_string,
    output utf8d_pkg::t_push    o_push
);

    logic [utf8d_pkg::CP_W-1:0]  r_acc,   n_acc;
    logic [utf8d_pkg::LEN_W-1:0] r_left,  n_left;
    logic [utf8d_pkg::LEN_W-1:0] r_total, n_total;

    utf8d_pkg::t_lead            lead;
    utf8d_pkg::t_result          lead_res;
    logic                        lead_has;
    logic [utf8d_pkg::CP_W-1:0]  lead_acc;
    logic [utf8d_pkg::LEN_W-1:0] lead_left;
    logic [utf8d_pkg::LEN_W-1:0] lead_total;

    logic [utf8d_pkg::CP_W-1:0]  cont_acc;
    logic [utf8d_pkg::LEN_W-1:0] cont_left;
    logic                        is_cont;

    utf8d_pkg::t_push            push;

    // Decode the byte as the first byte of a new sequence.
    always_comb begin
        lead       = utf8d_pkg::lead_decode(i_data_byte);
        lead_res   = '{codepoint: '0, seq_bytes: '0,
                       status: utf8d_pkg::ST_OK, final_result: 1'b0};
        lead_has   = 1'b1;
        lead_acc   = '0;
        lead_left  = '0;
        lead_total = '0;
        priority if (lead.len == 3'd1) begin
            lead_res.codepoint = {24'd0, i_data_byte[6:0]};
            lead_res.seq_bytes = 3'd1;
        end else if (lead.len == 3'd0 || int'(lead.len) > MAX_SEQ_BYTES) begin
            lead_res.status = utf8d_pkg::ST_ILLEGAL;
        end else if (i_end_of_string) begin
            lead_res.status = utf8d_pkg::ST_SHORT;
        end else begin
            // Start a multi-byte sequence; no result yet.
            lead_has   = 1'b0;
            lead_acc   = {24'd0, lead.payload};
            lead_total = lead.len;
            lead_left  = lead.len - 3'd1;
        end
    end

    // Continuation path: shift in six payload bits.
    assign is_cont   = (i_data_byte[7:6] == 2'b10);
    assign cont_acc  = {r_acc[utf8d_pkg::CP_W-7:0], i_data_byte[5:0]};
    assign cont_left = r_left - 3'd1;

    // Select the outcome for the current state and byte.
    always_comb begin
        push     = '0;
        n_acc    = r_acc;
        n_left   = r_left;
        n_total  = r_total;
        priority if (r_left == '0) begin
            push.cnt  = {1'b0, lead_has};
            push.res0 = lead_res;
            n_acc     = lead_acc;
            n_left    = lead_left;
            n_total   = lead_total;
        end else if (is_cont) begin
            if (cont_left == '0) begin
                // Sequence complete: check for an overlong form.
                push.cnt = 2'd1;
                if (cont_acc < utf8d_pkg::min_value(r_total)) begin
                    push.res0.status = utf8d_pkg::ST_OVERLONG;
                end else begin
                    push.res0.codepoint = cont_acc;
                    push.res0.seq_bytes = r_total;
                    push.res0.status    = utf8d_pkg::ST_OK;
                end
                n_acc   = '0;
                n_left  = '0;
                n_total = '0;
            end else if (i_end_of_string) begin
                push.cnt         = 2'd1;
                push.res0.status = utf8d_pkg::ST_SHORT;
                n_acc            = '0;
                n_left           = '0;
                n_total          = '0;
            end else begin
                n_acc  = cont_acc;
                n_left = cont_left;
            end
        end else begin
            // Broken sequence: report it, then decode the byte as a lead.
            push.res0.status = utf8d_pkg::ST_BADCONT;
            push.res1        = lead_res;
            push.cnt         = lead_has ? 2'd2 : 2'd1;
            n_acc            = lead_acc;
            n_left           = lead_left;
            n_total          = lead_total;
        end
        // Mark the last result of the end-of-string byte.
        if (i_end_of_string) begin
            if (push.cnt == 2'd2) begin
                push.res1.final_result = 1'b1;
            end else begin
                push.res0.final_result = 1'b1;
            end
        end
    end

    assign o_push = push;

    // Sequence state advances on each accepted transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_left  <= '0;
            r_total <= '0;
        end else if (i_accept) begin
            r_acc   <= n_acc;
            r_left  <= n_left;
            r_total <= n_total;
        end
    end

    // An idle decoder holds no partial value or length.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left == '0) |-> (r_total == '0 && r_acc == '0))
        else $error("idle decoder holds stale sequence state");

    // Bytes still expected are always fewer than the sequence length.
    a_left_lt_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != '0) |-> (r_left < r_total && int'(r_total) <= MAX_SEQ_BYTES))
        else $error("bytes left inconsistent with sequence length");

    // An end-of-string byte always yields at least one result.
    a_eos_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end_of_string) |-> (push.cnt != 2'd0))
        else $error("end-of-string byte produced no result");

endmodule

### rtl/utf8d_resq.sv
// Result queue: stores up to RESQ_DEPTH results, takes up to two per cycle while o_room is high, gives one.
// Depends on utf8d_pkg for the result and push types.
module utf8d_resq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  utf8d_pkg::t_push    i_push,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output utf8d_pkg::t_result  o_result
);

    localparam int DEPTH = utf8d_pkg::RESQ_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    utf8d_pkg::t_result  r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]    r_count,  n_count;
    logic [PTR_W-1:0]    wr_ptr_b;
    logic [1:0]          push_cnt;
    logic                pop;

    // Room for the two results a single byte may cause.
    assign o_room   = (r_count <= CNT_W'(DEPTH - 2));
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd_ptr];

    assign push_cnt = i_accept ? i_push.cnt : 2'd0;
    assign pop      = o_valid && i_ready;
    assign wr_ptr_b = r_wr_ptr + PTR_W'(1);

    // Pointer and occupancy update.
    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(push_cnt);
        n_rd_ptr = r_rd_ptr + PTR_W'(pop);
        n_count  = r_count + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Result storage, written at up to two consecutive entries.
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (push_cnt == 2'd2) begin
            r_mem[wr_ptr_b] <= i_push.res1;
        end
    end

    // Occupancy never exceeds the queue depth.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    // Bytes are only taken while two entries are free.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_cnt != 2'd0) |-> o_room)
        else $error("results pushed without room");

    // Occupancy tracks pushes and pops exactly.
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
        (r_count == $past(r_count) + CNT_W'($past(push_cnt)) - CNT_W'($past(pop))))
        else $error("result queue occupancy mismatch");

endmodule

### rtl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder (1 to 6 byte legacy forms).
// Depends on utf8d_pkg, utf8d_decode and utf8d_resq.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+----------------------------------------
//  byte in  | input     | i_valid / o_ready  | i_data_byte, i_end_of_string
//  result   | output    | o_valid / i_ready  | o_codepoint, o_seq_bytes, o_status,
//           |           |                    | o_final_result
//
// One byte is taken per cycle while o_ready is high; each byte is decoded in the cycle
// it is transferred and its results are written into the result queue.
// A broken sequence can give two results for one byte; the single output port then
// sets the long-run rate to one result per cycle while i_ready is high.
// o_ready is high while the four-entry result queue has two free entries, so a
// stalled output side holds up the input only once fewer than two entries are free.
// Reset (synchronous, active low) clears the sequence state and empties the queue.
module utf8_stream_decoder #(
    parameter int MAX_SEQ_BYTES = utf8d_pkg::MAX_SEQ_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_string,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [30:0] o_codepoint,
    output logic [2:0]  o_seq_bytes,
    output logic [2:0]  o_status,
    output logic        o_final_result
);

    logic               accept;
    logic               room;
    utf8d_pkg::t_push   push;
    utf8d_pkg::t_result result;

    // Input transfer.
    assign o_ready = room;
    assign accept  = i_valid && room;

    // Byte decode and sequence state.
    utf8d_decode #(
        .MAX_SEQ_BYTES (MAX_SEQ_BYTES)
    ) u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_string (i_end_of_string),
        .o_push          (push)
    );

    // Results wait here until the output transfer.
    utf8d_resq u_resq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result)
    );

    // Output fields.
    assign o_codepoint    = result.codepoint;
    assign o_seq_bytes    = result.seq_bytes;
    assign o_status       = result.status;
    assign o_final_result = result.final_result;

endmodule

### dv/tb.sv
// Self-checking testbench for utf8_stream_decoder: directed and random byte streams.
// Depends on utf8d_pkg and the utf8_stream_decoder RTL; predicts every result itself.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN = utf8d_pkg::MAX_SEQ_BYTES_DEF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_end_of_string = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [30:0] o_codepoint;
    logic [2:0]  o_seq_bytes;
    logic [2:0]  o_status;
    logic        o_final_result;

    // Percent of cycles in which each side holds off.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          error_count = 0;
    int          bytes_sent = 0;

    // Decoder state as predicted by the testbench.
    logic [30:0] acc_value = '0;
    logic [2:0]  cont_left = '0;
    logic [2:0]  seq_len = '0;

    // Results of one byte, and all results still awaited on the output.
    utf8d_pkg::t_result step_res [2];
    int                 step_cnt;
    utf8d_pkg::t_result awaited_results [$];

    // One encoded sequence ready to be sent.
    logic [7:0]  seq_buf [8];
    int          seq_n;

    utf8_stream_decoder #(.MAX_SEQ_BYTES(MAX_LEN)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_string (i_end_of_string),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_codepoint     (o_codepoint),
        .o_seq_bytes     (o_seq_bytes),
        .o_status        (o_status),
        .o_final_result  (o_final_result)
    );

    // 20 ns clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver side holds off at random.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Smallest value a sequence of length n may carry without being overlong.
    function automatic logic [31:0] lowest_legal(input int n);
        case (n)
            2: return 32'h80;
            3: return 32'h800;
            4: return 32'h10000;
            5: return 32'h200000;
            6: return 32'h4000000;
            default: return 32'h0;
        endcase
    endfunction

    function automatic void go_idle();
        acc_value = '0;
        cont_left = '0;
        seq_len   = '0;
    endfunction

    function automatic void emit(input logic [30:0] cp, input logic [2:0] len,
                                 input utf8d_pkg::t_status st);
        step_res[step_cnt].codepoint    = cp;
        step_res[step_cnt].seq_bytes    = len;
        step_res[step_cnt].status       = st;
        step_res[step_cnt].final_result = 1'b0;
        step_cnt++;
    endfunction

    // Decodes a byte seen while idle as the start of a new sequence.
    function automatic void take_lead_byte(input logic [7:0] b, input logic eos);
        int         n;
        logic [6:0] bits;
        n    = 0;
        bits = '0;
        casez (b)
            8'b0???????: begin n = 1; bits = b[6:0]; end
            8'b110?????: begin n = 2; bits = {2'b00, b[4:0]}; end
            8'b1110????: begin n = 3; bits = {3'b000, b[3:0]}; end
            8'b11110???: begin n = 4; bits = {4'b0000, b[2:0]}; end
            8'b111110??: begin n = 5; bits = {5'b00000, b[1:0]}; end
            8'b1111110?: begin n = 6; bits = {6'b000000, b[0]}; end
            default:     n = 0;
        endcase
        if (n == 1) begin
            emit({24'd0, bits}, 3'd1, utf8d_pkg::ST_OK);
        end else if (n == 0 || n > MAX_LEN) begin
            go_idle();
            emit('0, '0, utf8d_pkg::ST_ILLEGAL);
        end else begin
            acc_value = {24'd0, bits};
            seq_len   = n[2:0];
            cont_left = n[2:0] - 3'd1;
            if (eos) begin
                go_idle();
                emit('0, '0, utf8d_pkg::ST_SHORT);
            end
        end
    endfunction

    // Predicts the results of one transferred byte and queues them.
    function automatic void predict_decode(input logic [7:0] b, input logic eos);
        logic [2:0] len;
        step_cnt = 0;
        if (cont_left == 3'd0) begin
            take_lead_byte(b, eos);
        end else if (b[7:6] == 2'b10) begin
            acc_value = {acc_value[24:0], b[5:0]};
            cont_left = cont_left - 3'd1;
            if (cont_left == 3'd0) begin
                len = seq_len;
                if ({1'b0, acc_value} < lowest_legal(int'(len)))
                    emit('0, '0, utf8d_pkg::ST_OVERLONG);
                else
                    emit(acc_value, len, utf8d_pkg::ST_OK);
                go_idle();
            end else if (eos) begin
                go_idle();
                emit('0, '0, utf8d_pkg::ST_SHORT);
            end
        end else begin
            // A broken sequence: report it, then decode the byte again as a lead.
            go_idle();
            emit('0, '0, utf8d_pkg::ST_BADCONT);
            take_lead_byte(b, eos);
        end
        if (eos && step_cnt > 0)
            step_res[step_cnt-1].final_result = 1'b1;
        for (int k = 0; k < step_cnt; k++)
            awaited_results.push_back(step_res[k]);
    endfunction

    // Sends one byte, with random idle cycles ahead of it, and predicts on transfer.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_data_byte     <= b;
        i_end_of_string <= eos;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_decode(b, eos);
        bytes_sent++;
    endtask

    task automatic send_buffer(input logic eos_last);
        for (int k = 0; k < seq_n; k++)
            send_byte(seq_buf[k], eos_last && (k == seq_n - 1));
    endtask

    // Holds the sender off until every awaited result has arrived.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    // Encodes cp as an n-byte sequence; a small cp gives an overlong form.
    function automatic void encode_seq(input logic [30:0] cp, input int n);
        logic [30:0] v;
        v = cp;
        seq_n = n;
        for (int k = n - 1; k >= 1; k--) begin
            seq_buf[k] = {2'b10, v[5:0]};
            v = v >> 6;
        end
        case (n)
            1:       seq_buf[0] = {1'b0, v[6:0]};
            2:       seq_buf[0] = 8'hc0 | v[7:0];
            3:       seq_buf[0] = 8'he0 | v[7:0];
            4:       seq_buf[0] = 8'hf0 | v[7:0];
            5:       seq_buf[0] = 8'hf8 | v[7:0];
            default: seq_buf[0] = 8'hfc | v[7:0];
        endcase
    endfunction

    // Random legal value for a length, often at the ends of its range.
    function automatic logic [30:0] random_value(input int n);
        logic [31:0] lo;
        logic [31:0] hi;
        int unsigned pick;
        lo = lowest_legal(n);
        hi = (n == 6) ? 32'h7fffffff : lowest_legal(n + 1) - 32'd1;
        pick = $urandom_range(7);
        if (pick == 0)
            return lo[30:0];
        if (pick == 1)
            return hi[30:0];
        return lo[30:0] + 31'($urandom % (hi - lo + 32'd1));
    endfunction

    function automatic int random_length();
        if ($urandom_range(99) < 30)
            return 1;
        return $urandom_range(6, 2);
    endfunction

    function automatic logic [7:0] random_non_cont();
        logic [7:0] b;
        b = 8'($urandom);
        if (b[7:6] == 2'b10)
            b[6] = 1'b1;
        return b;
    endfunction

    // Extremes of lengths 1, 2 and 6, every error kind and four end-of-string cases.
    task automatic test_directed();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b1);
        send_byte(8'hc0, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hdf, 1'b0); send_byte(8'hbf, 1'b0);
        send_byte(8'hfc, 1'b0);
        repeat (5) send_byte(8'h80, 1'b0);
        send_byte(8'hfd, 1'b0);
        repeat (5) send_byte(8'hbf, 1'b0);
        // Stray continuation and the two bytes that never start a sequence.
        send_byte(8'h80, 1'b0);
        send_byte(8'hfe, 1'b0);
        send_byte(8'hff, 1'b0);
        // Broken sequences, one ending the string on the new lead.
        send_byte(8'hc3, 1'b0); send_byte(8'h41, 1'b0);
        send_byte(8'hc3, 1'b0); send_byte(8'hc3, 1'b1);
        // String ending inside a sequence and right on a lead byte.
        send_byte(8'he2, 1'b0); send_byte(8'h82, 1'b1);
        send_byte(8'hf8, 1'b1);
    endtask

    // Mostly well-formed text, with overlong, truncated, broken and noise bytes.
    task automatic test_random_text(input int n_bytes);
        int target;
        int kind;
        int n;
        int cut;
        target = bytes_sent + n_bytes;
        wait_for_drain();
        while (bytes_sent < target) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                n = random_length();
                encode_seq(random_value(n), n);
                send_buffer($urandom_range(9) == 0);
            end else if (kind < 78) begin
                n = $urandom_range(6, 2);
                encode_seq(31'($urandom % lowest_legal(n)), n);
                send_buffer($urandom_range(9) == 0);
            end else if (kind < 86) begin
                n = $urandom_range(6, 2);
                encode_seq(random_value(n), n);
                seq_n = $urandom_range(n - 1, 1);
                send_buffer($urandom_range(3) != 0);
            end else if (kind < 93) begin
                n = $urandom_range(6, 2);
                encode_seq(random_value(n), n);
                cut = $urandom_range(n - 1, 1);
                seq_buf[cut] = random_non_cont();
                send_buffer($urandom_range(9) == 0);
            end else begin
                repeat ($urandom_range(4, 1))
                    send_byte(8'($urandom), 1'($urandom_range(1)));
            end
            if ($urandom_range(99) == 0)
                wait_for_drain();
        end
    endtask

    // Pairs whose second byte gives two results; then the queue is left to empty.
    task automatic test_drain_pause();
        repeat (8) begin
            send_byte(8'hc3, 1'b0);
            send_byte(8'h41, 1'b0);
        end
        wait_for_drain();
        send_byte(8'h5a, 1'b1);
    endtask

    // Checks each transferred result against the oldest awaited one.
    always @(posedge i_clk) begin
        utf8d_pkg::t_result exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result cp %h len %0d status %0d final %b",
                         $time, o_codepoint, o_seq_bytes, o_status, o_final_result);
                error_count++;
            end else begin
                exp_res = awaited_results.pop_front();
                if (o_codepoint !== exp_res.codepoint) begin
                    $display("%0t: codepoint expected %h, got %h",
                             $time, exp_res.codepoint, o_codepoint);
                    error_count++;
                end
                if (o_seq_bytes !== exp_res.seq_bytes) begin
                    $display("%0t: seq_bytes expected %0d, got %0d",
                             $time, exp_res.seq_bytes, o_seq_bytes);
                    error_count++;
                end
                if (o_status !== exp_res.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, exp_res.status, o_status);
                    error_count++;
                end
                if (o_final_result !== exp_res.final_result) begin
                    $display("%0t: final_result expected %b, got %b",
                             $time, exp_res.final_result, o_final_result);
                    error_count++;
                end
            end
        end
    end

    // Test sequence.
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 30;
        recv_idle_pct = 63;
        test_directed();
        test_random_text(600);
        test_drain_pause();

        send_idle_pct = 63;
        recv_idle_pct = 30;
        test_random_text(600);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_text(600);

        i_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // Overall time limit.
    initial begin
        #5_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
